@@ rtl/wildcard_rule_classifier_core_defines.svh @@
// assertion macros for the wildcard rule classifier
`ifndef WILDCARD_RULE_CLASSIFIER_CORE_DEFINES_SVH
`define WILDCARD_RULE_CLASSIFIER_CORE_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off while rst_ni is low
`define WRC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("wrc assertion failed");

// next-cycle implication
`define WRC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("wrc assertion failed");

`endif

@@ rtl/wrc_pkg.sv @@
// shared types and constants of the wildcard rule classifier
`timescale 1ns / 1ps

package wrc_pkg;

  localparam int MAX_RULES   = 256;
  localparam int NUM_KEYS    = 9;
  localparam int KEY_W       = 32;
  localparam int TYPE_W      = 31;
  localparam int ENTRY_IDX_W = 8;
  localparam int IDX_W       = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int CNT_W       = $clog2(MAX_RULES + 1);

  typedef enum logic [1:0] {
    REQ_LOAD     = 2'd0,
    REQ_CLASSIFY = 2'd1,
    REQ_CLEAR    = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } state_e;

  typedef logic [NUM_KEYS-1:0][KEY_W-1:0] keys_t;

  typedef struct packed {
    logic [TYPE_W-1:0] src;
    keys_t             keys;
    logic [TYPE_W-1:0] tgt;
  } entry_t;

endpackage

@@ rtl/wrc_ram.sv @@
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module wrc_ram #(
  parameter int Width = 32,
  parameter int Depth = 256,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/wrc_match.sv @@
// wildcard compare of one stored rule against an event
`timescale 1ns / 1ps

module wrc_match (
  input  wrc_pkg::entry_t                entry_i,
  input  logic [wrc_pkg::TYPE_W-1:0]     src_i,
  input  wrc_pkg::keys_t                 keys_i,
  output logic                           match_o
);

  logic [wrc_pkg::NUM_KEYS-1:0] key_ok;

  always_comb begin
    for (int k = 0; k < wrc_pkg::NUM_KEYS; k++) begin
      // all ones in a rule key matches anything
      key_ok[k] = (entry_i.keys[k] == '1) || (entry_i.keys[k] == keys_i[k]);
    end
  end

  assign match_o = (entry_i.src == src_i) && (&key_ok);

endmodule

@@ rtl/wildcard_rule_classifier_core.sv @@
// Wildcard first-match rule table: top level.
// Input channel (in_valid_i / in_ready_o) takes one request per transaction:
// load appends a rule (status set if the table is full), classify searches the table, clear empties it.
// Output channel (out_valid_o / out_ready_i) returns exactly one result per
// request: hit, entry_index, out_event_type and status.
// Rules live in one entry memory (source type, nine keys, target type) with
// a registered read. Classify reads one entry per cycle in load order and
// stops at the first match; a miss is returned once every loaded entry has
// been checked. Load, clear and unused codes skip the scan and go straight
// to the response state.
// A request is processed one at a time; the next one can be taken in the
// cycle after the previous result is moved into the output register.
// The output register holds a result while the receiver stalls, and the
// next request can be accepted meanwhile; its result waits until the
// output register is free.
// Reset empties the table (entry count zero) and drops any pending result;
// memory contents are left as they are and never read past the count.
`timescale 1ns / 1ps

`include "wildcard_rule_classifier_core_defines.svh"

module wildcard_rule_classifier_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  req_type_i,
  input  logic [30:0] source_event_type_i,
  input  logic signed [31:0] in_event_type_i,
  input  logic signed [31:0] long_type_i,
  input  logic signed [31:0] roam_type_i,
  input  logic signed [31:0] calling_sp_type_i,
  input  logic signed [31:0] called_sp_type_i,
  input  logic signed [31:0] calling_service_type_i,
  input  logic signed [31:0] called_service_type_i,
  input  logic signed [31:0] carrier_type_i,
  input  logic signed [31:0] service_key_i,
  input  logic [30:0] target_event_type_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        hit_o,
  output logic [7:0]  entry_index_o,
  output logic [30:0] out_event_type_o,
  output logic        status_o
);

  localparam int IdxW  = wrc_pkg::IDX_W;
  localparam int CntW  = wrc_pkg::CNT_W;
  localparam int TypeW = wrc_pkg::TYPE_W;

  wrc_pkg::state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] iss_q, iss_d;
  logic            chk_vld_q, chk_vld_d;
  logic [IdxW-1:0] chk_idx_q;

  // captured event for classify
  logic [TypeW-1:0] src_q;
  wrc_pkg::keys_t   keys_q;
  wrc_pkg::keys_t   in_keys;

  // pending result
  logic             res_hit_q, res_hit_d;
  logic [IdxW-1:0]  res_idx_q, res_idx_d;
  logic [TypeW-1:0] res_tgt_q, res_tgt_d;
  logic             res_st_q, res_st_d;

  // output register
  logic             out_valid_q, out_valid_d;
  logic             out_load;
  logic             out_hit_q;
  logic [IdxW-1:0]  out_idx_q;
  logic [TypeW-1:0] out_tgt_q;
  logic             out_st_q;

  logic             accept;
  logic             ram_we;
  logic             rd_en;
  logic             match_now;
  logic             match_raw;
  wrc_pkg::entry_t  wr_entry;
  wrc_pkg::entry_t  rd_entry;

  assign in_keys = {service_key_i, carrier_type_i, called_service_type_i,
                    calling_service_type_i, called_sp_type_i, calling_sp_type_i,
                    roam_type_i, long_type_i, in_event_type_i};

  assign in_ready_o = (state_q == wrc_pkg::ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  assign wr_entry.src  = source_event_type_i;
  assign wr_entry.keys = in_keys;
  assign wr_entry.tgt  = target_event_type_i;

  wrc_ram #(
    .Width ($bits(wrc_pkg::entry_t)),
    .Depth (wrc_pkg::MAX_RULES)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[IdxW-1:0]),
    .wdata_i (wr_entry),
    .re_i    (rd_en),
    .raddr_i (iss_q[IdxW-1:0]),
    .rdata_o (rd_entry)
  );

  wrc_match u_match (
    .entry_i (rd_entry),
    .src_i   (src_q),
    .keys_i  (keys_q),
    .match_o (match_raw)
  );

  assign match_now = chk_vld_q && match_raw;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    iss_d     = iss_q;
    res_hit_d = res_hit_q;
    res_idx_d = res_idx_q;
    res_tgt_d = res_tgt_q;
    res_st_d  = res_st_q;
    ram_we    = 1'b0;
    rd_en     = 1'b0;
    chk_vld_d = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      wrc_pkg::ST_IDLE: begin
        if (accept) begin
          res_hit_d = 1'b0;
          res_idx_d = '0;
          res_tgt_d = '0;
          res_st_d  = 1'b0;
          state_d   = wrc_pkg::ST_RESP;
          case (wrc_pkg::req_e'(req_type_i))
            wrc_pkg::REQ_LOAD: begin
              if (cnt_q == CntW'(wrc_pkg::MAX_RULES)) begin
                res_st_d = 1'b1;
              end else begin
                ram_we    = 1'b1;
                cnt_d     = cnt_q + 1'b1;
                res_idx_d = cnt_q[IdxW-1:0];
              end
            end
            wrc_pkg::REQ_CLASSIFY: begin
              iss_d   = '0;
              state_d = wrc_pkg::ST_SCAN;
            end
            wrc_pkg::REQ_CLEAR: begin
              cnt_d = '0;
            end
            default: begin
            end
          endcase
        end
      end
      wrc_pkg::ST_SCAN: begin
        rd_en = (iss_q != cnt_q);
        if (rd_en) begin
          iss_d = iss_q + 1'b1;
        end
        if (match_now) begin
          res_hit_d = 1'b1;
          res_idx_d = chk_idx_q;
          res_tgt_d = rd_entry.tgt;
          state_d   = wrc_pkg::ST_RESP;
        end else if (iss_q == cnt_q) begin
          // all entries issued and the last one checked: miss
          state_d = wrc_pkg::ST_RESP;
        end else begin
          chk_vld_d = 1'b1;
        end
      end
      wrc_pkg::ST_RESP: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = wrc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = wrc_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wrc_pkg::ST_IDLE;
      cnt_q       <= '0;
      iss_q       <= '0;
      chk_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      iss_q       <= iss_d;
      chk_vld_q   <= chk_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      src_q  <= source_event_type_i;
      keys_q <= in_keys;
    end
    if (rd_en) begin
      chk_idx_q <= iss_q[IdxW-1:0];
    end
    res_hit_q <= res_hit_d;
    res_idx_q <= res_idx_d;
    res_tgt_q <= res_tgt_d;
    res_st_q  <= res_st_d;
    if (out_load) begin
      out_hit_q <= res_hit_q;
      out_idx_q <= res_idx_q;
      out_tgt_q <= res_tgt_q;
      out_st_q  <= res_st_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign hit_o            = out_hit_q;
  assign entry_index_o    = wrc_pkg::ENTRY_IDX_W'(out_idx_q);
  assign out_event_type_o = out_tgt_q;
  assign status_o         = out_st_q;

  `WRC_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= CntW'(wrc_pkg::MAX_RULES))
  `WRC_ASSERT_NOW(a_iss_bound, state_q == wrc_pkg::ST_SCAN, iss_q <= cnt_q)
  `WRC_ASSERT_NOW(a_chk_in_scan, chk_vld_q, state_q == wrc_pkg::ST_SCAN)
  `WRC_ASSERT_NEXT(a_load_out, out_load, out_valid_q && state_q == wrc_pkg::ST_IDLE)

endmodule
